// ----- rtl/rde_pkg.sv -----
// shared types and constants for the radix digit emitter
package rde_pkg;

  localparam int unsigned SymCount    = 16;
  localparam int unsigned SymByteW    = 8;
  localparam int unsigned DigitW      = 4;
  localparam int unsigned BaseW       = 5;
  localparam int unsigned CfgDataW    = 64;
  localparam int unsigned CfgIndexW   = 1;
  localparam int unsigned BitsPerStep = 8;

  localparam logic [SymByteW-1:0] CharPlus  = 8'h2B;
  localparam logic [SymByteW-1:0] CharMinus = 8'h2D;
  localparam logic [SymByteW-1:0] CharNul   = 8'h00;

  localparam logic [CfgIndexW-1:0] RegSymbolsLow  = 1'b0;
  localparam logic [CfgIndexW-1:0] RegSymbolsHigh = 1'b1;

  // symbol table, entry 0 in the lowest byte
  typedef logic [SymCount-1:0][SymByteW-1:0] sym_table_t;

  // queue occupancy seen by the front end
  typedef struct packed {
    logic full;
    logic empty;
  } queue_status_t;

  typedef enum logic [4:0] {
    ST_IDLE   = 5'b00001,
    ST_DIVIDE = 5'b00010,
    ST_SIGN   = 5'b00100,
    ST_READ   = 5'b01000,
    ST_EMIT   = 5'b10000
  } back_state_e;

endpackage

// ----- rtl/rde_front.sv -----
// front end: symbol registers, alphabet check, request intake and sign split
module rde_front #(
  parameter int unsigned MAX_SYMBOLS = 16,
  parameter int unsigned NUMBER_BITS = 32
) (
  input  logic                               clk_i,
  input  logic                               rst_ni,
  input  logic                               cfg_we_i,
  input  logic [rde_pkg::CfgIndexW-1:0]      cfg_index_i,
  input  logic [rde_pkg::CfgDataW-1:0]       cfg_wdata_i,
  input  logic                               in_valid_i,
  output logic                               in_stall_o,
  input  logic signed [NUMBER_BITS-1:0]      number_i,
  input  rde_pkg::queue_status_t             q_status_i,
  output logic                               q_push_o,
  output logic [NUMBER_BITS:0]               q_data_o,
  output rde_pkg::sym_table_t                sym_o,
  output logic [rde_pkg::BaseW-1:0]          base_o
);

  logic [rde_pkg::CfgDataW-1:0] sym_low_q, sym_high_q;
  logic [rde_pkg::BaseW-1:0]    base_d, base_q;
  logic [rde_pkg::BaseW-1:0]    len;
  logic                         bad;
  rde_pkg::sym_table_t          sym;
  logic [NUMBER_BITS-1:0]       raw, mag;
  logic                         neg;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      sym_low_q  <= '0;
      sym_high_q <= '0;
      base_q     <= '0;
    end else begin
      base_q <= base_d;
      if (cfg_we_i) begin
        unique case (cfg_index_i)
          rde_pkg::RegSymbolsLow:  sym_low_q  <= cfg_wdata_i;
          rde_pkg::RegSymbolsHigh: sym_high_q <= cfg_wdata_i;
          default: ;
        endcase
      end
    end
  end

  assign sym = {sym_high_q, sym_low_q};

  // alphabet length up to the first zero byte
  always_comb begin
    logic stop;
    stop = 1'b0;
    len  = '0;
    for (int i = 0; i < rde_pkg::SymCount; i++) begin
      if (i < MAX_SYMBOLS && !stop && sym[i] != rde_pkg::CharNul) begin
        len = rde_pkg::BaseW'(i + 1);
      end else begin
        stop = 1'b1;
      end
    end
  end

  // sign characters and repeated symbols spoil the alphabet
  always_comb begin
    bad = 1'b0;
    for (int i = 0; i < rde_pkg::SymCount; i++) begin
      if (rde_pkg::BaseW'(i) < len &&
          (sym[i] == rde_pkg::CharPlus || sym[i] == rde_pkg::CharMinus)) begin
        bad = 1'b1;
      end
      for (int j = 0; j < rde_pkg::SymCount; j++) begin
        if (j > i && rde_pkg::BaseW'(j) < len && sym[i] == sym[j]) begin
          bad = 1'b1;
        end
      end
    end
  end

  assign base_d = (len < rde_pkg::BaseW'(2) || bad) ? '0 : len;

  // magnitude taken as unsigned, so the most negative value is exact
  assign raw = number_i;
  assign neg = raw[NUMBER_BITS-1];
  assign mag = neg ? (~raw + NUMBER_BITS'(1)) : raw;

  // with a bad alphabet a request is taken and dropped; intake sees the
  // alphabet of the current registers, even right after a write
  assign in_stall_o = (base_d != '0) && q_status_i.full;
  assign q_push_o   = in_valid_i && !in_stall_o && (base_d != '0);
  assign q_data_o   = {neg, mag};
  assign sym_o      = sym;
  assign base_o     = base_q;

endmodule

// ----- rtl/rde_queue.sv -----
// two-entry queue between front and back ends
module rde_queue #(
  parameter int unsigned DATA_W = 33
) (
  input  logic                  clk_i,
  input  logic                  rst_ni,
  input  logic                  push_i,
  input  logic [DATA_W-1:0]     data_i,
  input  logic                  pop_i,
  output logic [DATA_W-1:0]     data_o,
  output rde_pkg::queue_status_t status_o
);

  logic [DATA_W-1:0] mem_q [2];
  logic              wr_ptr_q, rd_ptr_q;
  logic [1:0]        cnt_q;

  always_ff @(posedge clk_i) begin
    if (push_i) begin
      mem_q[wr_ptr_q] <= data_i;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= 1'b0;
      rd_ptr_q <= 1'b0;
      cnt_q    <= '0;
    end else begin
      if (push_i) wr_ptr_q <= ~wr_ptr_q;
      if (pop_i)  rd_ptr_q <= ~rd_ptr_q;
      cnt_q <= cnt_q + 2'(push_i) - 2'(pop_i);
    end
  end

  assign data_o         = mem_q[rd_ptr_q];
  assign status_o.full  = (cnt_q == 2'd2);
  assign status_o.empty = (cnt_q == 2'd0);

endmodule

// ----- rtl/rde_back.sv -----
// back end: digit extraction by the base, digit store and character output
module rde_back #(
  parameter int unsigned NUMBER_BITS = 32
) (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  input  rde_pkg::queue_status_t        q_status_i,
  input  logic [NUMBER_BITS:0]          q_data_i,
  output logic                          q_pop_o,
  input  rde_pkg::sym_table_t           sym_i,
  input  logic [rde_pkg::BaseW-1:0]     base_i,
  output logic                          out_valid_o,
  input  logic                          out_stall_i,
  output logic [rde_pkg::SymByteW-1:0]  character_o,
  output logic                          last_o
);

  localparam int unsigned Steps = (NUMBER_BITS + rde_pkg::BitsPerStep - 1) /
                                  rde_pkg::BitsPerStep;
  localparam int unsigned DivW  = Steps * rde_pkg::BitsPerStep;
  localparam int unsigned StepW = (Steps > 1) ? $clog2(Steps) : 1;
  localparam int unsigned CntW  = $clog2(NUMBER_BITS + 1);
  localparam int unsigned AddrW = $clog2(NUMBER_BITS);
  localparam int unsigned Bps   = rde_pkg::BitsPerStep;

  rde_pkg::back_state_e state_q, state_d;

  logic [DivW-1:0]              div_q, div_d;
  logic [StepW-1:0]             step_q, step_d;
  logic [rde_pkg::DigitW-1:0]   rem_q, rem_d;
  logic                         qnz_q, qnz_d;
  logic                         neg_q, neg_d;
  logic [CntW-1:0]              cnt_q, cnt_d;

  logic [rde_pkg::DigitW-1:0]   mem_q [NUMBER_BITS];
  logic [rde_pkg::DigitW-1:0]   rd_q;
  logic [AddrW-1:0]             rd_addr;
  logic [CntW-1:0]              rd_sub;
  logic                         wr_en;

  logic [Bps-1:0]               qbyte;
  logic [rde_pkg::DigitW-1:0]   step_rem;
  logic                         slot_free, emit_go;

  logic                         out_valid_q, out_valid_d;
  logic [rde_pkg::SymByteW-1:0] char_q, char_d;
  logic                         last_q, last_d;

  // one byte of restoring division per cycle, remainder stays below the base
  always_comb begin
    logic [rde_pkg::BaseW-1:0] r;
    r     = {1'b0, rem_q};
    qbyte = '0;
    for (int b = Bps - 1; b >= 0; b--) begin
      r = {r[rde_pkg::DigitW-1:0], div_q[DivW - Bps + b]};
      if (r >= base_i) begin
        r        = r - base_i;
        qbyte[b] = 1'b1;
      end
    end
    step_rem = r[rde_pkg::DigitW-1:0];
  end

  assign slot_free = !out_valid_q || !out_stall_i;
  assign emit_go   = (state_q == rde_pkg::ST_EMIT) && slot_free;
  assign rd_sub    = cnt_q - CntW'(1) - CntW'(emit_go);
  assign rd_addr   = rd_sub[AddrW-1:0];

  always_comb begin
    state_d     = state_q;
    div_d       = div_q;
    step_d      = step_q;
    rem_d       = rem_q;
    qnz_d       = qnz_q;
    neg_d       = neg_q;
    cnt_d       = cnt_q;
    q_pop_o     = 1'b0;
    wr_en       = 1'b0;
    out_valid_d = out_valid_q && out_stall_i;
    char_d      = char_q;
    last_d      = last_q;
    unique case (state_q)
      rde_pkg::ST_IDLE: begin
        if (!q_status_i.empty) begin
          q_pop_o = 1'b1;
          div_d   = DivW'(q_data_i[NUMBER_BITS-1:0]);
          neg_d   = q_data_i[NUMBER_BITS];
          step_d  = '0;
          rem_d   = '0;
          qnz_d   = 1'b0;
          cnt_d   = '0;
          state_d = rde_pkg::ST_DIVIDE;
        end
      end
      rde_pkg::ST_DIVIDE: begin
        div_d = (div_q << Bps) | DivW'(qbyte);
        rem_d = step_rem;
        qnz_d = qnz_q || (qbyte != '0);
        step_d = step_q + StepW'(1);
        if (step_q == StepW'(Steps - 1)) begin
          // quotient complete, remainder is the next digit
          wr_en  = 1'b1;
          cnt_d  = cnt_q + CntW'(1);
          step_d = '0;
          rem_d  = '0;
          qnz_d  = 1'b0;
          if (!(qnz_q || (qbyte != '0))) begin
            state_d = neg_q ? rde_pkg::ST_SIGN : rde_pkg::ST_READ;
          end
        end
      end
      rde_pkg::ST_SIGN: begin
        if (slot_free) begin
          out_valid_d = 1'b1;
          char_d      = rde_pkg::CharMinus;
          last_d      = 1'b0;
          state_d     = rde_pkg::ST_READ;
        end
      end
      rde_pkg::ST_READ: begin
        state_d = rde_pkg::ST_EMIT;
      end
      rde_pkg::ST_EMIT: begin
        if (slot_free) begin
          out_valid_d = 1'b1;
          char_d      = sym_i[rd_q];
          last_d      = (cnt_q == CntW'(1));
          cnt_d       = cnt_q - CntW'(1);
          if (cnt_q == CntW'(1)) begin
            state_d = rde_pkg::ST_IDLE;
          end
        end
      end
      default: state_d = rde_pkg::ST_IDLE;
    endcase
  end

  // digit store: written while dividing, read one digit ahead while emitting
  always_ff @(posedge clk_i) begin
    if (wr_en) begin
      mem_q[cnt_q[AddrW-1:0]] <= step_rem;
    end
    rd_q <= mem_q[rd_addr];
  end

  always_ff @(posedge clk_i) begin
    div_q  <= div_d;
    rem_q  <= rem_d;
    neg_q  <= neg_d;
    char_q <= char_d;
    last_q <= last_d;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= rde_pkg::ST_IDLE;
      step_q      <= '0;
      qnz_q       <= 1'b0;
      cnt_q       <= '0;
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      step_q      <= step_d;
      qnz_q       <= qnz_d;
      cnt_q       <= cnt_d;
      out_valid_q <= out_valid_d;
    end
  end

  assign out_valid_o = out_valid_q;
  assign character_o = char_q;
  assign last_o      = last_q;

endmodule

// ----- rtl/radix_digit_emitter_unit.sv -----
// top level of the radix digit emitter: writes signed integers as characters
//
// usage
//   config port: cfg_we_i writes cfg_wdata_i into register cfg_index_i;
//   index 0 holds symbols 0..7, index 1 symbols 8..15, low byte first. the
//   alphabet ends at the first zero byte; write it only while the unit is idle
//   input channel: number_i is taken when in_valid_i is high and in_stall_o low.
//   with a bad alphabet (under two symbols, a sign symbol, a repeat) requests
//   are taken and produce no characters
//   output channel: one character per digit on character_o, last_o marks
//   the final one; a negative number starts with a minus sign
// timing
//   the front end takes a request per cycle into a two-entry queue while the
//   queue is not full. the back end handles one number at a time: it loads
//   the number, divides it once per digit (one byte of restoring division per
//   cycle), sends the minus sign for a negative number, primes the digit
//   store, then gives one character per cycle while the output is not stalled
// reset clears the queue, the sequencer and the output valid flag; the symbol
// registers reset to zero, an empty alphabet
// a stalled output holds its character and the back end waits before its next
// character; the queue keeps taking requests until full
module radix_digit_emitter_unit #(
  parameter int unsigned MAX_SYMBOLS = 16,
  parameter int unsigned NUMBER_BITS = 32
) (
  input  logic                               clk_i,
  input  logic                               rst_ni,
  input  logic                               cfg_we_i,
  input  logic [rde_pkg::CfgIndexW-1:0]      cfg_index_i,
  input  logic [rde_pkg::CfgDataW-1:0]       cfg_wdata_i,
  input  logic                               in_valid_i,
  output logic                               in_stall_o,
  input  logic signed [NUMBER_BITS-1:0]      number_i,
  output logic                               out_valid_o,
  input  logic                               out_stall_i,
  output logic [rde_pkg::SymByteW-1:0]       character_o,
  output logic                               last_o
);

  // queue entry: sign on top, magnitude below
  logic [NUMBER_BITS:0]          push_data, pop_data;
  logic                          push, pop;
  rde_pkg::queue_status_t        q_status;
  rde_pkg::sym_table_t           sym;
  logic [rde_pkg::BaseW-1:0]     base;

  // intake and alphabet check
  rde_front #(
    .MAX_SYMBOLS (MAX_SYMBOLS),
    .NUMBER_BITS (NUMBER_BITS)
  ) u_front (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cfg_we_i    (cfg_we_i),
    .cfg_index_i (cfg_index_i),
    .cfg_wdata_i (cfg_wdata_i),
    .in_valid_i  (in_valid_i),
    .in_stall_o  (in_stall_o),
    .number_i    (number_i),
    .q_status_i  (q_status),
    .q_push_o    (push),
    .q_data_o    (push_data),
    .sym_o       (sym),
    .base_o      (base)
  );

  // decouples intake from conversion
  rde_queue #(
    .DATA_W (NUMBER_BITS + 1)
  ) u_queue (
    .clk_i    (clk_i),
    .rst_ni   (rst_ni),
    .push_i   (push),
    .data_i   (push_data),
    .pop_i    (pop),
    .data_o   (pop_data),
    .status_o (q_status)
  );

  // digit extraction and character output
  rde_back #(
    .NUMBER_BITS (NUMBER_BITS)
  ) u_back (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .q_status_i  (q_status),
    .q_data_i    (pop_data),
    .q_pop_o     (pop),
    .sym_i       (sym),
    .base_i      (base),
    .out_valid_o (out_valid_o),
    .out_stall_i (out_stall_i),
    .character_o (character_o),
    .last_o      (last_o)
  );

endmodule
